### rtl/core/qpe_pkg.sv
// Package for the quoted-printable encoder core.
// Holds the payload structs, character constants and small helper functions.
// No dependencies.
package qpe_pkg;

    localparam int QPE_DEPTH = 9;   // most characters one word can cause
    localparam int QPE_CNT_W = 4;   // holds 0..QPE_DEPTH
    localparam int QPE_SEGS  = 5;   // output segments per word
    localparam int QPE_LEN_W = 7;

    localparam logic [QPE_LEN_W-1:0] SOFT_LIMIT = 7'd70;

    localparam logic [7:0] CHR_TAB = 8'd9;
    localparam logic [7:0] CHR_LF  = 8'd10;
    localparam logic [7:0] CHR_CR  = 8'd13;
    localparam logic [7:0] CHR_SP  = 8'd32;
    localparam logic [7:0] CHR_EQ  = 8'd61;
    localparam logic [7:0] CHR_0   = 8'd48;
    localparam logic [7:0] CHR_A   = 8'd65;
    localparam logic [7:0] CHR_D   = 8'd68;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } qpe_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
        logic       message_end;
    } qpe_out_t;

    // up to three characters, c[0] goes out first
    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][7:0] c;
    } qpe_seg_t;

    // characters of one word, chars[0] goes out first
    typedef struct packed {
        logic [QPE_DEPTH-1:0][7:0] chars;
        logic [QPE_CNT_W-1:0]      cnt;
        logic                      is_end;
    } qpe_plan_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'd0, nib};
        return (nib < 4'd10) ? (CHR_0 + n8) : (CHR_A + n8 - 8'd10);
    endfunction

    function automatic qpe_seg_t mk_seg(input logic [1:0] len, input logic [7:0] c0,
                                        input logic [7:0] c1, input logic [7:0] c2);
        qpe_seg_t s;
        s.len  = len;
        s.c[0] = c0;
        s.c[1] = c1;
        s.c[2] = c2;
        return s;
    endfunction

endpackage

### rtl/core/qpe_plan.sv
// Encoder state and the combinational expansion of one word into characters.
// Depends on qpe_pkg.
module qpe_plan import qpe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  qpe_in_t   in_word,
    input  logic      step,        // commit this word's state update
    output qpe_plan_t plan
);

    logic                 text_mode_reg;
    logic [QPE_LEN_W-1:0] line_len_reg, line_len_next;
    logic                 cr_pend_reg, cr_pend_next;
    logic                 blank_reg, blank_next;

    qpe_seg_t [QPE_SEGS-1:0] seg;

    logic [7:0]           b;
    logic                 is_end, sb, lf_case, flush, hold_cr, pass, emit_byte;
    logic [QPE_LEN_W-1:0] len0, len1;
    qpe_seg_t             seg_sb, seg_none;

    always_comb begin
        b        = in_word.data_byte;
        is_end   = (in_word.req_type == REQ_END);
        seg_sb   = mk_seg(2'd3, CHR_EQ, CHR_CR, CHR_LF);
        seg_none = mk_seg(2'd0, CHR_EQ, CHR_EQ, CHR_EQ);
        sb       = (line_len_reg > SOFT_LIMIT);
        lf_case  = text_mode_reg && cr_pend_reg && (b == CHR_LF);
        flush    = text_mode_reg && cr_pend_reg && (b != CHR_LF);
        hold_cr  = text_mode_reg && (b == CHR_CR);
        emit_byte = !lf_case && !hold_cr;
        pass     = ((b >= 8'd33) && (b <= 8'd60)) || ((b >= 8'd62) && (b <= 8'd126)) ||
                   (b == CHR_TAB) || (b == CHR_SP);
        len0     = sb ? '0 : line_len_reg;
        len1     = flush ? len0 + 7'd3 : len0;

        seg = {QPE_SEGS{seg_none}};
        if (is_end) begin
            seg[0] = seg_sb;
            if (text_mode_reg && cr_pend_reg) begin
                seg[1] = mk_seg(2'd3, CHR_EQ, CHR_0, CHR_D);
                seg[2] = seg_sb;
            end
        end else begin
            if (sb) seg[0] = seg_sb;
            // hard break after a blank needs a soft break first
            if (lf_case && !sb && blank_reg) seg[1] = seg_sb;
            if (lf_case) seg[2] = mk_seg(2'd2, CHR_CR, CHR_LF, CHR_LF);
            if (flush) seg[3] = mk_seg(2'd3, CHR_EQ, CHR_0, CHR_D);
            if (emit_byte) begin
                seg[4] = pass ? mk_seg(2'd1, b, b, b)
                              : mk_seg(2'd3, CHR_EQ, hex_char(b[7:4]), hex_char(b[3:0]));
            end
        end
    end

    // pack the segments back to back
    always_comb begin
        logic [QPE_CNT_W-1:0] pos;
        pos         = '0;
        plan.chars  = '0;
        for (int i = 0; i < QPE_SEGS; i++) begin
            for (int k = 0; k < 3; k++) begin
                if (k < int'(seg[i].len) && pos < QPE_CNT_W'(QPE_DEPTH)) begin
                    plan.chars[pos] = seg[i].c[k];
                    pos = pos + QPE_CNT_W'(1);
                end
            end
        end
        plan.cnt    = pos;
        plan.is_end = is_end;
    end

    always_comb begin
        if (is_end) begin
            line_len_next = '0;
            cr_pend_next  = 1'b0;
            blank_next    = 1'b0;
        end else begin
            if (lf_case)        line_len_next = '0;
            else if (hold_cr)   line_len_next = len1;
            else if (pass)      line_len_next = len1 + 7'd1;
            else                line_len_next = len1 + 7'd3;
            cr_pend_next = text_mode_reg ? (b == CHR_CR) : cr_pend_reg;
            if (plan.cnt == '0) blank_next = blank_reg;
            else blank_next = emit_byte && pass && ((b == CHR_TAB) || (b == CHR_SP));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_mode_reg <= 1'b0;
            line_len_reg  <= '0;
            cr_pend_reg   <= 1'b0;
            blank_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) text_mode_reg <= cfg_wr_data;
            if (step) begin
                line_len_reg <= line_len_next;
                cr_pend_reg  <= cr_pend_next;
                blank_reg    <= blank_next;
            end
        end
    end

endmodule

### rtl/core/qpe_serial.sv
// Result buffer: holds one word's characters and shifts them out one per cycle while m_ready is high.
// Depends on qpe_pkg.
module qpe_serial import qpe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  qpe_plan_t plan,
    output logic      buf_free,    // a load may happen this cycle
    output logic      m_valid,
    input  logic      m_ready,
    output qpe_out_t  m_data
);

    logic [QPE_DEPTH-1:0][7:0] buf_reg;
    logic [QPE_CNT_W-1:0]      cnt_reg;
    logic                      end_reg;
    logic                      take;

    assign m_valid  = (cnt_reg != '0);
    assign take     = m_valid && m_ready;
    assign buf_free = (cnt_reg == '0) || ((cnt_reg == QPE_CNT_W'(1)) && m_ready);

    assign m_data.out_char    = buf_reg[0];
    assign m_data.last_of_run = (cnt_reg == QPE_CNT_W'(1));
    assign m_data.message_end = (cnt_reg == QPE_CNT_W'(1)) && end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            end_reg <= 1'b0;
        end else if (load) begin
            cnt_reg <= plan.cnt;
            end_reg <= plan.is_end;
        end else if (take) begin
            cnt_reg <= cnt_reg - QPE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= plan.chars;
        end else if (take) begin
            buf_reg <= {8'd0, buf_reg[QPE_DEPTH-1:1]};
        end
    end

endmodule

### rtl/core/quoted_printable_encoder_core.sv
// Quoted-printable encoder core, top level. Uses qpe_pkg, qpe_plan, qpe_serial.
// Path: an accepted word passes the input register, then the result buffer.
// Output: one character per cycle on m_ while m_ready is high; a word yields
// 1..9 characters (3 for an escaped byte itself), sent by the output shifter;
// the next word can load as the last character of the previous one is taken.
// A held CR yields none and retires from the input register without the buffer.
// Reset: aresetn synchronous active low; clears text_mode and encoder state.
module quoted_printable_encoder_core import qpe_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    // configuration: text_mode
    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data,
    // input words
    input  logic     s_valid,
    output logic     s_ready,
    input  qpe_in_t  s_data,
    // encoded characters
    output logic     m_valid,
    input  logic     m_ready,
    output qpe_out_t m_data
);

    // Input register: one word waits here until the result buffer can take
    // its characters.
    logic      in_valid_reg;
    qpe_in_t   in_word_reg;

    qpe_plan_t plan;
    logic      buf_free;
    logic      consume;   // word leaves the input register, state advances
    logic      load;      // its characters enter the result buffer

    // A word that yields nothing (a held CR) retires without the buffer.
    assign consume = in_valid_reg && ((plan.cnt == '0) || buf_free);
    assign load    = consume && (plan.cnt != '0);
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // State (line length, pending CR, last blank) and character expansion.
    qpe_plan u_plan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_word     (in_word_reg),
        .step        (consume),
        .plan        (plan)
    );

    // Result register, shifted out one character a cycle while m_ready is high.
    qpe_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .plan     (plan),
        .buf_free (buf_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### rtl/core/qpe_checker.sv
// Port-level checks for the quoted-printable encoder core, with its bind.
// Depends on qpe_pkg and quoted_printable_encoder_core.
module qpe_checker import qpe_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input qpe_out_t m_data
);

    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output changed while stalled");

    // message end is always the last character of its run
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.message_end |-> m_data.last_of_run)
        else $error("message_end without last_of_run");

    // a run's characters follow without gaps
    a_run_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_run |=> m_valid)
        else $error("gap inside a run");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind quoted_printable_encoder_core qpe_checker u_qpe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
